// ===== sv/ltt_pkg.sv =====
// ----------------------------------------------------------------------------
// ltt_pkg: shared types and constants of the lambda term tokenizer
// Token kinds, error codes, scan modes, keyword tracker codes, character
// codes and the token record passed between the scanner and the queue.
// ----------------------------------------------------------------------------
package ltt_pkg;

    // Scan mode of the front end
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_SWALLOW = 3'd4
    } scan_mode_t;

    // Token kinds as seen on the output
    typedef enum logic [3:0] {
        KIND_LAM    = 4'd0,
        KIND_VAR    = 4'd1,
        KIND_NUM    = 4'd2,
        KIND_STR    = 4'd3,
        KIND_LPAREN = 4'd4,
        KIND_RPAREN = 4'd5,
        KIND_DOT    = 4'd6,
        KIND_ASSIGN = 4'd7,
        KIND_LET    = 4'd8,
        KIND_IN     = 4'd9,
        KIND_END    = 4'd10,
        KIND_ERROR  = 4'd11
    } token_kind_t;

    // Error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_UNEXPECTED   = 3'd1;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW     = 3'd3;
    localparam logic [2:0] ERR_NULL_CHAR    = 3'd4;

    // Keyword tracker codes
    localparam logic [2:0] KW_START = 3'd0;
    localparam logic [2:0] KW_L     = 3'd1;
    localparam logic [2:0] KW_LE    = 3'd2;
    localparam logic [2:0] KW_LET   = 3'd3;
    localparam logic [2:0] KW_I     = 3'd4;
    localparam logic [2:0] KW_IN    = 3'd5;
    localparam logic [2:0] KW_NONE  = 3'd7;

    // Field widths
    localparam int CODE_W   = 21;
    localparam int NUMBER_W = 64;
    localparam int POS_W    = 32;

    // Character codes
    localparam logic [CODE_W-1:0] CH_NUL       = 21'h00;
    localparam logic [CODE_W-1:0] CH_TAB       = 21'h09;
    localparam logic [CODE_W-1:0] CH_CR        = 21'h0D;
    localparam logic [CODE_W-1:0] CH_SPACE     = 21'h20;
    localparam logic [CODE_W-1:0] CH_QUOTE     = 21'h22;
    localparam logic [CODE_W-1:0] CH_HASH      = 21'h23;
    localparam logic [CODE_W-1:0] CH_LPAREN    = 21'h28;
    localparam logic [CODE_W-1:0] CH_RPAREN    = 21'h29;
    localparam logic [CODE_W-1:0] CH_DOT       = 21'h2E;
    localparam logic [CODE_W-1:0] CH_DIGIT_0   = 21'h30;
    localparam logic [CODE_W-1:0] CH_DIGIT_9   = 21'h39;
    localparam logic [CODE_W-1:0] CH_SEMICOLON = 21'h3B;
    localparam logic [CODE_W-1:0] CH_EQUALS    = 21'h3D;
    localparam logic [CODE_W-1:0] CH_UPPER_A   = 21'h41;
    localparam logic [CODE_W-1:0] CH_UPPER_Z   = 21'h5A;
    localparam logic [CODE_W-1:0] CH_BACKSLASH = 21'h5C;
    localparam logic [CODE_W-1:0] CH_UNDERSCORE = 21'h5F;
    localparam logic [CODE_W-1:0] CH_LOWER_A   = 21'h61;
    localparam logic [CODE_W-1:0] CH_LOWER_E   = 21'h65;
    localparam logic [CODE_W-1:0] CH_LOWER_I   = 21'h69;
    localparam logic [CODE_W-1:0] CH_LOWER_L   = 21'h6C;
    localparam logic [CODE_W-1:0] CH_LOWER_N   = 21'h6E;
    localparam logic [CODE_W-1:0] CH_LOWER_T   = 21'h74;
    localparam logic [CODE_W-1:0] CH_LOWER_Z   = 21'h7A;
    localparam logic [CODE_W-1:0] CH_LAMBDA    = 21'h3BB;

    // One output token
    typedef struct packed {
        token_kind_t           kind;
        logic [NUMBER_W-1:0]   number;
        logic [POS_W-1:0]      start;
        logic [POS_W-1:0]      length;
        logic [2:0]            err;
        logic                  last;
    } token_t;

    // Tokens produced by one accepted request
    typedef struct packed {
        logic [1:0] count;
        token_t     slot0;
        token_t     slot1;
    } push_t;

    // Token queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 136;

endpackage

// ===== sv/ltt_scanner.sv =====
// ----------------------------------------------------------------------------
// ltt_scanner: front end of the lambda term tokenizer
// Classifies one code point per accepted request, keeps the scan mode and
// the partial token state, and hands zero, one or two tokens to the queue.
// ----------------------------------------------------------------------------
module ltt_scanner #(
    parameter int POSITION_WIDTH = 32,
    parameter int NUMBER_WIDTH   = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [ltt_pkg::CODE_W-1:0]  code_point,
    input  logic                        end_marker,
    output ltt_pkg::push_t              push
);

    ltt_pkg::scan_mode_t          mode_reg, mode_next;
    logic [2:0]                   kw_reg, kw_next_val;
    logic [NUMBER_WIDTH-1:0]      acc_reg, acc_next;
    logic [POSITION_WIDTH-1:0]    start_reg, start_next;
    logic [POSITION_WIDTH-1:0]    length_reg, length_next;
    logic [POSITION_WIDTH-1:0]    pos_reg, pos_next;

    // Character classes
    logic is_letter, is_digit, is_space, is_lam, is_cont, is_quote;
    logic [NUMBER_WIDTH+3:0]      acc_sum;
    logic                         acc_ovf;
    logic [POSITION_WIDTH-1:0]    length_inc;

    // Idle scan results
    logic                         idle_emit;
    ltt_pkg::token_t              idle_tok;
    ltt_pkg::scan_mode_t          idle_mode;

    // Finished tokens built from held state
    ltt_pkg::token_t              ident_tok, num_tok, str_tok;

    logic                         pre_v, post_v;
    ltt_pkg::token_t              pre_t, post_t;

    // Advance the keyword tracker by one character
    function automatic logic [2:0] kw_next(input logic [2:0] m,
                                           input logic [ltt_pkg::CODE_W-1:0] c);
        logic [2:0] r;
        r = ltt_pkg::KW_NONE;
        priority if (m == ltt_pkg::KW_START)
        begin
            if (c == ltt_pkg::CH_LOWER_L)
                r = ltt_pkg::KW_L;
            else if (c == ltt_pkg::CH_LOWER_I)
                r = ltt_pkg::KW_I;
        end
        else if (m == ltt_pkg::KW_L && c == ltt_pkg::CH_LOWER_E)
            r = ltt_pkg::KW_LE;
        else if (m == ltt_pkg::KW_LE && c == ltt_pkg::CH_LOWER_T)
            r = ltt_pkg::KW_LET;
        else if (m == ltt_pkg::KW_I && c == ltt_pkg::CH_LOWER_N)
            r = ltt_pkg::KW_IN;
        else
            r = ltt_pkg::KW_NONE;
        return r;
    endfunction

    // Classify the incoming character
    always_comb
    begin
        is_letter = (code_point >= ltt_pkg::CH_UPPER_A && code_point <= ltt_pkg::CH_UPPER_Z)
                 || (code_point >= ltt_pkg::CH_LOWER_A && code_point <= ltt_pkg::CH_LOWER_Z)
                 || (code_point == ltt_pkg::CH_LAMBDA);
        is_digit  = code_point >= ltt_pkg::CH_DIGIT_0 && code_point <= ltt_pkg::CH_DIGIT_9;
        is_space  = (code_point == ltt_pkg::CH_SPACE)
                 || (code_point >= ltt_pkg::CH_TAB && code_point <= ltt_pkg::CH_CR);
        is_lam    = (code_point == ltt_pkg::CH_HASH) || (code_point == ltt_pkg::CH_BACKSLASH)
                 || (code_point == ltt_pkg::CH_LAMBDA);
        is_cont   = is_letter || is_digit || (code_point == ltt_pkg::CH_UNDERSCORE);
        is_quote  = code_point == ltt_pkg::CH_QUOTE;
    end

    // Accumulate a digit: acc*10 + d, with the carry out flagging overflow
    always_comb
    begin
        acc_sum = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                + (NUMBER_WIDTH + 4)'(code_point[3:0]);
        acc_ovf = acc_sum[NUMBER_WIDTH+3:NUMBER_WIDTH] != 4'd0;
        length_inc = length_reg + POSITION_WIDTH'(1);
    end

    // Scan a character as the first one of a token
    always_comb
    begin
        idle_emit = 1'b0;
        idle_tok  = '0;
        idle_mode = ltt_pkg::MODE_IDLE;
        priority if (is_lam)
        begin
            idle_emit     = 1'b1;
            idle_tok.kind = ltt_pkg::KIND_LAM;
        end
        else if (is_letter)
            idle_mode = ltt_pkg::MODE_IDENT;
        else if (is_digit)
            idle_mode = ltt_pkg::MODE_NUMBER;
        else if (is_quote)
            idle_mode = ltt_pkg::MODE_STRING;
        else if (is_space || code_point == ltt_pkg::CH_SEMICOLON)
        begin
            idle_mode = ltt_pkg::MODE_IDLE;
        end
        else if (code_point == ltt_pkg::CH_LPAREN)
        begin
            idle_emit     = 1'b1;
            idle_tok.kind = ltt_pkg::KIND_LPAREN;
        end
        else if (code_point == ltt_pkg::CH_RPAREN)
        begin
            idle_emit     = 1'b1;
            idle_tok.kind = ltt_pkg::KIND_RPAREN;
        end
        else if (code_point == ltt_pkg::CH_DOT)
        begin
            idle_emit     = 1'b1;
            idle_tok.kind = ltt_pkg::KIND_DOT;
        end
        else if (code_point == ltt_pkg::CH_EQUALS)
        begin
            idle_emit     = 1'b1;
            idle_tok.kind = ltt_pkg::KIND_ASSIGN;
        end
        else
        begin
            idle_mode     = ltt_pkg::MODE_SWALLOW;
            idle_emit     = 1'b1;
            idle_tok.kind = ltt_pkg::KIND_ERROR;
            idle_tok.err  = (code_point == ltt_pkg::CH_NUL) ? ltt_pkg::ERR_NULL_CHAR
                                                            : ltt_pkg::ERR_UNEXPECTED;
        end
    end

    // Build tokens from the held identifier, number and string state
    always_comb
    begin
        ident_tok = '0;
        if (kw_reg == ltt_pkg::KW_LET)
            ident_tok.kind = ltt_pkg::KIND_LET;
        else if (kw_reg == ltt_pkg::KW_IN)
            ident_tok.kind = ltt_pkg::KIND_IN;
        else
        begin
            ident_tok.kind   = ltt_pkg::KIND_VAR;
            ident_tok.start  = ltt_pkg::POS_W'(start_reg);
            ident_tok.length = ltt_pkg::POS_W'(length_reg);
        end
        num_tok        = '0;
        num_tok.kind   = ltt_pkg::KIND_NUM;
        num_tok.number = ltt_pkg::NUMBER_W'(acc_reg);
        str_tok        = '0;
        str_tok.kind   = ltt_pkg::KIND_STR;
        str_tok.start  = ltt_pkg::POS_W'(start_reg);
        str_tok.length = ltt_pkg::POS_W'(length_inc);
    end

    // Next scan state
    always_comb
    begin
        logic take_idle;
        take_idle   = 1'b0;
        mode_next   = mode_reg;
        kw_next_val = kw_reg;
        acc_next    = acc_reg;
        start_next  = start_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        if (accept)
        begin
            if (end_marker)
            begin
                mode_next   = ltt_pkg::MODE_IDLE;
                kw_next_val = ltt_pkg::KW_START;
                acc_next    = '0;
                start_next  = '0;
                length_next = '0;
                pos_next    = '0;
            end
            else
            begin
                pos_next = pos_reg + POSITION_WIDTH'(1);
                unique case (mode_reg)
                    ltt_pkg::MODE_IDLE:
                        take_idle = 1'b1;
                    ltt_pkg::MODE_IDENT:
                    begin
                        if (is_cont)
                        begin
                            length_next = length_inc;
                            kw_next_val = kw_next(kw_reg, code_point);
                        end
                        else
                            take_idle = 1'b1;
                    end
                    ltt_pkg::MODE_NUMBER:
                    begin
                        if (is_digit)
                        begin
                            if (acc_ovf)
                                mode_next = ltt_pkg::MODE_SWALLOW;
                            else
                                acc_next = acc_sum[NUMBER_WIDTH-1:0];
                        end
                        else
                            take_idle = 1'b1;
                    end
                    ltt_pkg::MODE_STRING:
                    begin
                        length_next = length_inc;
                        if (is_quote)
                            mode_next = ltt_pkg::MODE_IDLE;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
                // Start a new token from this character
                if (take_idle)
                begin
                    mode_next = idle_mode;
                    if (idle_mode == ltt_pkg::MODE_IDENT)
                    begin
                        start_next  = pos_reg;
                        length_next = POSITION_WIDTH'(1);
                        kw_next_val = kw_next(ltt_pkg::KW_START, code_point);
                    end
                    else if (idle_mode == ltt_pkg::MODE_NUMBER)
                        acc_next = NUMBER_WIDTH'(code_point[3:0]);
                    else if (idle_mode == ltt_pkg::MODE_STRING)
                    begin
                        start_next  = pos_reg;
                        length_next = POSITION_WIDTH'(1);
                    end
                end
            end
        end
    end

    // Tokens caused by this request: one that ends a token, one that it scans
    always_comb
    begin
        pre_v  = 1'b0;
        pre_t  = '0;
        post_v = 1'b0;
        post_t = '0;
        if (end_marker)
        begin
            unique case (mode_reg)
                ltt_pkg::MODE_IDENT:
                begin
                    pre_v = 1'b1;
                    pre_t = ident_tok;
                end
                ltt_pkg::MODE_NUMBER:
                begin
                    pre_v = 1'b1;
                    pre_t = num_tok;
                end
                ltt_pkg::MODE_STRING:
                begin
                    pre_v      = 1'b1;
                    pre_t.kind = ltt_pkg::KIND_ERROR;
                    pre_t.err  = ltt_pkg::ERR_UNTERMINATED;
                end
                default:
                begin
                    pre_v = 1'b0;
                end
            endcase
            post_v      = 1'b1;
            post_t.kind = ltt_pkg::KIND_END;
        end
        else
        begin
            unique case (mode_reg)
                ltt_pkg::MODE_IDLE:
                begin
                    post_v = idle_emit;
                    post_t = idle_tok;
                end
                ltt_pkg::MODE_IDENT:
                begin
                    if (!is_cont)
                    begin
                        pre_v  = 1'b1;
                        pre_t  = ident_tok;
                        post_v = idle_emit;
                        post_t = idle_tok;
                    end
                end
                ltt_pkg::MODE_NUMBER:
                begin
                    if (is_digit)
                    begin
                        post_v      = acc_ovf;
                        post_t.kind = ltt_pkg::KIND_ERROR;
                        post_t.err  = ltt_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        pre_v  = 1'b1;
                        pre_t  = num_tok;
                        post_v = idle_emit;
                        post_t = idle_tok;
                    end
                end
                ltt_pkg::MODE_STRING:
                begin
                    post_v = is_quote;
                    post_t = str_tok;
                end
                default:
                begin
                    post_v = 1'b0;
                end
            endcase
        end
    end

    // Pack the tokens in order and mark the last one
    always_comb
    begin
        push       = '0;
        push.slot0 = pre_v ? pre_t : post_t;
        push.slot1 = post_t;
        if (accept)
            push.count = {1'b0, pre_v} + {1'b0, post_v};
        if (push.count == 2'd2)
            push.slot1.last = 1'b1;
        else
            push.slot0.last = 1'b1;
    end

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ltt_pkg::MODE_IDLE;
            kw_reg     <= ltt_pkg::KW_START;
            acc_reg    <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            kw_reg     <= kw_next_val;
            acc_reg    <= acc_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// ===== sv/ltt_token_queue.sv =====
// ----------------------------------------------------------------------------
// ltt_token_queue: back end of the lambda term tokenizer
// Short token queue that takes up to two tokens per cycle from the scanner while it
// has room for two, and hands one token per cycle to the output while out_ready is high.
// ----------------------------------------------------------------------------
module ltt_token_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  ltt_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output ltt_pkg::token_t out_token
);

    ltt_pkg::token_t                  entry_reg [ltt_pkg::QUEUE_DEPTH];
    logic [ltt_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ltt_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ltt_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic [ltt_pkg::QUEUE_PTR_W-1:0]  wr_ptr_plus1;
    logic                             pop;

    // Accept a request only when two tokens fit
    assign room      = count_reg <= ltt_pkg::QUEUE_CNT_W'(ltt_pkg::QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_token = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + ltt_pkg::QUEUE_PTR_W'(1);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ltt_pkg::QUEUE_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + ltt_pkg::QUEUE_PTR_W'(pop);
        count_next  = count_reg + ltt_pkg::QUEUE_CNT_W'(push.count)
                    - ltt_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the tokens of one request in order
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.slot0;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.slot1;
    end

endmodule

// ===== sv/lambda_term_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// lambda_term_tokenizer_core: streaming tokenizer for a lambda-calculus text
// Input stream: one code point per request, or an end marker in s_tuser.
// Output stream: one token per request, m_tlast on the last token that an
// input request caused.
// A token is written into the token queue when the input request that causes it
// is accepted, and is offered on m_tvalid once the tokens ahead of it have left.
// Throughput: one code point per cycle while tokens drain as fast as they are
// made; a request that ends one token and starts another puts two tokens in
// the four-entry token queue, and those leave it one per output transfer.
// s_tready is high while the queue holds at most two tokens, so the scanner
// keeps taking input while the receiver holds off m_tready, until the
// queue holds more than two tokens.
// Reset empties the queue and starts a new stream at offset zero; an end
// marker emits END and does the same for the scan state.
// After an ERROR token, input is dropped until the end marker, and tokens
// already emitted in that stream are to be discarded downstream.
// ----------------------------------------------------------------------------
module lambda_term_tokenizer_core #(
    parameter int POSITION_WIDTH = 32,
    parameter int NUMBER_WIDTH   = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ltt_pkg::S_TDATA_W-1:0] s_tdata,   // [20:0] code_point
    input  logic                          s_tuser,   // [0] end_marker
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ltt_pkg::M_TDATA_W-1:0] m_tdata,   // [63:0] number_value,
                                                     // [95:64] token_start,
                                                     // [127:96] token_length,
                                                     // [130:128] error_code
    output logic [3:0]                    m_tuser,   // [3:0] token_kind
    output logic                          m_tlast    // last_of_run
);

    logic             accept;
    logic             room;
    ltt_pkg::push_t   push;
    ltt_pkg::token_t  head;

    // Take a request while the queue has room for two tokens
    assign s_tready = room;
    assign accept   = s_tvalid && room;

    ltt_scanner #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .NUMBER_WIDTH   (NUMBER_WIDTH)
    ) u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .code_point (s_tdata[ltt_pkg::CODE_W-1:0]),
        .end_marker (s_tuser),
        .push       (push)
    );

    ltt_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_token (head)
    );

    // Pack the head token onto the output stream
    assign m_tdata = {5'd0, head.err, head.length, head.start, head.number};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
